@@ rtl/text_byte_and_field_cutter_unit_assert.svh @@
// assertion macros shared by the cutter controller and datapath
// expects signals named clk and rst in the including module
`ifndef TEXT_BYTE_AND_FIELD_CUTTER_UNIT_ASSERT_SVH
`define TEXT_BYTE_AND_FIELD_CUTTER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define TBFC_ASSERT_NOW(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define TBFC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define TBFC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/tbfc_pkg.sv @@
// shared types and constants of the text byte and field cutter
// no dependencies
`default_nettype none

package tbfc_pkg;

  localparam int unsigned CFG_DATA_W  = 64;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned IN_DATA_W   = 32;
  localparam int unsigned OUT_DATA_W  = 8;
  localparam int unsigned POS_W       = 13;
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned FIELD_NUM_W = 7;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] CFG_SELECT_MODE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DELIMITER      = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_FIELD_MASK     = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_POSITION_COUNT = 2'd3;

  // input word kinds carried in tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_TEXT = 1'b1;

  // select_mode values
  localparam logic MODE_BYTES  = 1'b0;
  localparam logic MODE_FIELDS = 1'b1;

  localparam logic [7:0] NEWLINE_BYTE = 8'd10;
  localparam logic [7:0] SPACE_BYTE   = 8'd32;

  // controller to datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic idx_clear;  // restart the position list walk
    logic pos_rd;     // read position list at walk index
    logic idx_inc;    // step walk index
    logic byte_rd;    // read line store at registered position
    logic emit_byte;  // load line store byte into output register
    logic emit_nl;    // load closing newline, clear line length
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;    // output register holds a word not taken this cycle
    logic in_newline;  // word at input is a text newline
    logic byte_mode;   // select_mode is byte positions
    logic need_space;  // newline must be preceded by a space
    logic walk_done;   // walk index reached position count
    logic pos_ok;      // registered position lies inside the line
  } stat_t;

endpackage

`default_nettype wire

@@ rtl/tbfc_datapath.sv @@
// datapath of the cutter: config registers, line store, position list,
// field tracking and output register; uses tbfc_pkg and the assert header
`default_nettype none
`include "text_byte_and_field_cutter_unit_assert.svh"

module tbfc_datapath #(
  parameter int unsigned LINE_DEPTH    = 4096,
  parameter int unsigned MAX_POSITIONS = 63,
  parameter int unsigned MAX_FIELDS    = 64
) (
  input  wire                                 clk,
  input  wire                                 rst,
  input  wire                                 cfg_we,
  input  wire  [tbfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [tbfc_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  wire  [tbfc_pkg::IN_DATA_W-1:0]      in_data,
  input  wire                                 in_kind,
  input  wire                                 m_axis_tready,
  output logic [tbfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                m_axis_tlast,
  output logic                                m_axis_tvalid,
  input  tbfc_pkg::cmd_t                      cmd,
  output tbfc_pkg::stat_t                     stat
);
  import tbfc_pkg::*;

  localparam int unsigned AW = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int unsigned LW = $clog2(LINE_DEPTH + 1);
  localparam int unsigned CW = (LW > POS_W) ? LW : POS_W;
  localparam int unsigned PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;

  // configuration
  logic                  select_mode;
  logic [7:0]            delimiter;
  logic [CFG_DATA_W-1:0] field_mask;
  logic [SLOT_W-1:0]     position_count;

  // line and field state
  logic [LW-1:0]          line_length;
  logic [FIELD_NUM_W-1:0] field_number;
  logic                   field_nonempty;

  // memories
  logic [7:0]       line_store [LINE_DEPTH];
  logic [POS_W-1:0] position_list [MAX_POSITIONS];
  logic [7:0]       store_q;
  logic [POS_W-1:0] pos_q;
  logic [SLOT_W-1:0] walk_idx;

  // output register
  logic       out_valid;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_load;
  logic [7:0] load_byte;
  logic       load_last;

  logic [7:0]        in_byte;
  logic [SLOT_W-1:0] in_slot;
  logic [POS_W-1:0]  in_pos;
  logic              take_text;
  logic              is_newline;
  logic              is_delim;
  logic              selected;
  logic              store_room;
  logic [5:0]        field_idx;
  logic [SLOT_W-1:0] walk_count;
  logic [POS_W-1:0]  pos_m1;

  assign in_byte    = in_data[7:0];
  assign in_slot    = in_data[13:8];
  assign in_pos     = in_data[26:14];
  assign is_newline = (in_byte == NEWLINE_BYTE);
  assign is_delim   = (in_byte == delimiter);
  assign take_text  = cmd.accept && (in_kind == ACT_TEXT);
  assign store_room = (line_length < LW'(LINE_DEPTH));
  assign field_idx  = 6'(field_number - 7'd1);
  assign selected   = (field_number >= 7'd1) && (field_number <= FIELD_NUM_W'(MAX_FIELDS))
                      && field_mask[field_idx];
  assign walk_count = (position_count > SLOT_W'(MAX_POSITIONS)) ?
                      SLOT_W'(MAX_POSITIONS) : position_count;
  assign pos_m1     = pos_q - POS_W'(1);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      select_mode    <= MODE_FIELDS;
      delimiter      <= 8'd9;
      field_mask     <= '0;
      position_count <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SELECT_MODE:    select_mode    <= cfg_data[0];
        CFG_DELIMITER:      delimiter      <= cfg_data[7:0];
        CFG_FIELD_MASK:     field_mask     <= cfg_data;
        CFG_POSITION_COUNT: position_count <= cfg_data[SLOT_W-1:0];
        default: ;
      endcase
    end
  end

  // line length and field tracking
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length    <= '0;
      field_number   <= FIELD_NUM_W'(1);
      field_nonempty <= 1'b0;
    end else begin
      if (take_text) begin
        if (is_newline) begin
          field_number   <= FIELD_NUM_W'(1);
          field_nonempty <= 1'b0;
          // byte mode keeps the length until the walk is finished
          if (select_mode == MODE_FIELDS) begin
            line_length <= '0;
          end
        end else begin
          if (store_room) begin
            line_length <= line_length + LW'(1);
          end
          if (is_delim) begin
            if (field_number <= FIELD_NUM_W'(MAX_FIELDS)) begin
              field_number <= field_number + FIELD_NUM_W'(1);
            end
            field_nonempty <= 1'b0;
          end else begin
            field_nonempty <= 1'b1;
          end
        end
      end
      if (cmd.emit_nl) begin
        line_length <= '0;
      end
    end
  end

  // line store, written in arrival order, read during the walk
  always_ff @(posedge clk) begin
    if (take_text && !is_newline && store_room) begin
      line_store[line_length[AW-1:0]] <= in_byte;
    end
    if (cmd.byte_rd) begin
      store_q <= line_store[AW'(pos_m1)];
    end
  end

  // position list
  always_ff @(posedge clk) begin
    if (cmd.accept && (in_kind == ACT_LOAD) && (in_slot < SLOT_W'(MAX_POSITIONS))) begin
      position_list[in_slot[PW-1:0]] <= in_pos;
    end
    if (cmd.pos_rd) begin
      pos_q <= position_list[walk_idx[PW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      walk_idx <= '0;
    end else if (cmd.idx_clear) begin
      walk_idx <= '0;
    end else if (cmd.idx_inc) begin
      walk_idx <= walk_idx + SLOT_W'(1);
    end
  end

  // output word selection
  always_comb begin
    out_load  = 1'b0;
    load_byte = NEWLINE_BYTE;
    load_last = 1'b1;
    if (take_text && (select_mode == MODE_FIELDS)) begin
      if (is_newline) begin
        out_load = 1'b1;
        if (stat.need_space) begin
          load_byte = SPACE_BYTE;
          load_last = 1'b0;
        end
      end else if (selected) begin
        out_load  = 1'b1;
        load_byte = is_delim ? SPACE_BYTE : in_byte;
      end
    end
    if (cmd.emit_byte) begin
      out_load  = 1'b1;
      load_byte = store_q;
      load_last = 1'b0;
    end
    if (cmd.emit_nl) begin
      out_load = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= load_byte;
      out_last <= load_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_byte;
  assign m_axis_tlast  = out_last;

  assign stat.out_busy   = out_valid && !m_axis_tready;
  assign stat.in_newline = (in_kind == ACT_TEXT) && is_newline;
  assign stat.byte_mode  = (select_mode == MODE_BYTES);
  assign stat.need_space = (select_mode == MODE_FIELDS) && field_nonempty && selected;
  assign stat.walk_done  = (walk_idx == walk_count);
  assign stat.pos_ok     = (pos_q != '0) && ((CW'(pos_q) - CW'(1)) < CW'(line_length));

  `TBFC_ASSERT_NXT(a_nl_clears_line, cmd.emit_nl, line_length == '0, "line not cleared after newline")
  `TBFC_ASSERT_NOW(a_field_range, (field_number >= 7'd1) && (field_number <= FIELD_NUM_W'(MAX_FIELDS + 1)), "field number out of range")
  `TBFC_ASSERT_IMP(a_walk_in_list, cmd.pos_rd, walk_idx < walk_count, "position read past list")

endmodule

`default_nettype wire

@@ rtl/tbfc_ctrl.sv @@
// controller of the cutter: input acceptance and the byte mode list walk
// uses tbfc_pkg and the assert header
`default_nettype none
`include "text_byte_and_field_cutter_unit_assert.svh"

module tbfc_ctrl (
  input  wire              clk,
  input  wire              rst,
  input  wire              s_axis_tvalid,
  output logic             s_axis_tready,
  input  tbfc_pkg::stat_t  stat,
  output tbfc_pkg::cmd_t   cmd
);
  import tbfc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_POS   = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_BYTE  = 3'd3;
  localparam logic [2:0] S_NL    = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign s_axis_tready = (state == S_IDLE) && !stat.out_busy;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid && s_axis_tready) begin
          cmd.accept = 1'b1;
          if (stat.in_newline) begin
            if (stat.byte_mode) begin
              cmd.idx_clear = 1'b1;
              state_next    = S_POS;
            end else if (stat.need_space) begin
              state_next = S_NL;
            end
          end
        end
      end
      S_POS: begin
        if (stat.walk_done) begin
          state_next = S_NL;
        end else begin
          cmd.pos_rd = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.pos_ok) begin
          cmd.byte_rd = 1'b1;
          state_next  = S_BYTE;
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_POS;
        end
      end
      S_BYTE: begin
        if (!stat.out_busy) begin
          cmd.emit_byte = 1'b1;
          cmd.idx_inc   = 1'b1;
          state_next    = S_POS;
        end
      end
      S_NL: begin
        if (!stat.out_busy) begin
          cmd.emit_nl = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `TBFC_ASSERT_IMP(a_emit_when_free, cmd.emit_byte || cmd.emit_nl, !stat.out_busy, "output overwritten")
  `TBFC_ASSERT_IMP(a_byte_after_check, state == S_BYTE, ($past(state) == S_CHECK) || ($past(state) == S_BYTE), "byte state entered without a position check")
  `TBFC_ASSERT_NXT(a_walk_starts, cmd.accept && stat.in_newline && stat.byte_mode, state == S_POS, "byte mode newline did not start the walk")

endmodule

`default_nettype wire

@@ rtl/text_byte_and_field_cutter_unit.sv @@
// Text byte and field cutter. Input words on s_axis are either text bytes
// (tuser 1) or position list loads (tuser 0). In field mode each text byte
// is taken when the output register is free, and its output word (selected
// byte, or a space at a delimiter) follows from the output register; a
// newline that closes a selected nonempty field gives a space then the
// newline, two output words. In byte mode the line is kept in a line store
// and a newline starts a walk of the position list: for each list entry the
// position list is read, then the position is range checked, and if it lies
// inside the line the line store is read and the byte is emitted; at the end
// of the list the closing newline is emitted. Emitting waits while the output
// side stalls. The walk is set by the registered reads of the position list
// and the line store, one after the other. No input word is taken during the
// walk. The stores need no clearing after reset. Configuration is written
// over cfg_we/cfg_index/cfg_data; the user must do so only while the block
// is idle, which the block itself does not enforce.
// depends on tbfc_pkg, tbfc_ctrl, tbfc_datapath
`default_nettype none

module text_byte_and_field_cutter_unit #(
  parameter int unsigned LINE_DEPTH    = 4096,  // bytes of a line kept for byte mode
  parameter int unsigned MAX_POSITIONS = 63,    // entries of the position list
  parameter int unsigned MAX_FIELDS    = 64     // highest field number that can be selected
) (
  input  wire                                 clk,
  input  wire                                 rst,
  // input words
  input  wire                                 s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire  [tbfc_pkg::IN_DATA_W-1:0]      s_axis_tdata,  // text_byte, list_slot, byte_position, zero pad
  input  wire                                 s_axis_tuser,  // action
  // output words
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [tbfc_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // out_byte
  output logic                                m_axis_tlast,  // last_of_run
  // configuration writes
  input  wire                                 cfg_we,
  input  wire  [tbfc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [tbfc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import tbfc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // state machine: accepts words, sequences the byte mode walk
  tbfc_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // registers, stores, field tracking and the output register
  tbfc_datapath #(
    .LINE_DEPTH    (LINE_DEPTH),
    .MAX_POSITIONS (MAX_POSITIONS),
    .MAX_FIELDS    (MAX_FIELDS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_data       (s_axis_tdata),
    .in_kind       (s_axis_tuser),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .cmd           (cmd),
    .stat          (stat)
  );

endmodule

`default_nettype wire

@@ test/cutter_checker.sv @@
`timescale 1ns / 100ps
// scoreboard for the text cutter: snoops config writes, input and output words,
// predicts every output word and compares them in order
// depends on tbfc_pkg
module cutter_checker (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               s_axis_tvalid,
  input  wire                               s_axis_tready,
  input  wire  [tbfc_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // text_byte, list_slot, byte_position, pad
  input  wire                               s_axis_tuser,   // action
  input  wire                               m_axis_tvalid,
  input  wire                               m_axis_tready,
  input  wire  [tbfc_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // out_byte
  input  wire                               m_axis_tlast,   // last_of_run
  input  wire                               cfg_we,
  input  wire  [tbfc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [tbfc_pkg::CFG_DATA_W-1:0]   cfg_data,
  output int unsigned                       fail_count,
  output int unsigned                       words_due,
  output int unsigned                       words_checked
);
  import tbfc_pkg::*;

  localparam int unsigned LINE_DEPTH    = 4096;
  localparam int unsigned MAX_POSITIONS = 63;
  localparam int unsigned MAX_FIELDS    = 64;
  localparam int unsigned MAX_PRINTS    = 40;

  typedef struct packed {
    logic [7:0] value;
    logic       last;
  } cut_word_t;

  // mirrored configuration
  logic             mode;
  logic [7:0]       delim;
  logic [63:0]      fmask;
  logic [5:0]       pos_count;

  // mirrored line and field tracking
  logic [7:0]       line_buf [LINE_DEPTH];
  int unsigned      line_len;
  logic [POS_W-1:0] pos_list [MAX_POSITIONS];
  int unsigned      field_num;
  bit               field_has_bytes;

  cut_word_t        cut_q[$];

  initial begin
    fail_count    = 0;
    words_due     = 0;
    words_checked = 0;
  end

  task automatic report_mismatch(string msg);
    if (fail_count < MAX_PRINTS) $display("mismatch at %0t ns: %s", $time, msg);
    fail_count++;
  endtask

  function automatic bit field_on(int unsigned n);
    if (n < 1 || n > MAX_FIELDS) return 1'b0;
    return fmask[n-1];
  endfunction

  // works out the output words caused by one input word
  function automatic void predict_cut(logic act, logic [7:0] b, logic [5:0] slot,
                                      logic [POS_W-1:0] pos);
    logic [7:0]  run[$];
    cut_word_t   w;
    int unsigned cnt;
    if (act == ACT_LOAD) begin
      if (slot < MAX_POSITIONS) pos_list[slot] = pos;
      return;
    end
    if (b == NEWLINE_BYTE) begin
      if (mode == MODE_BYTES) begin
        cnt = (pos_count > MAX_POSITIONS) ? MAX_POSITIONS : pos_count;
        for (int i = 0; i < cnt; i++) begin
          // position zero and positions past the line end are skipped
          if (pos_list[i] >= 1 && pos_list[i] <= line_len) run.push_back(line_buf[pos_list[i]-1]);
        end
      end else if (field_has_bytes && field_on(field_num)) begin
        run.push_back(SPACE_BYTE);
      end
      run.push_back(NEWLINE_BYTE);
      line_len        = 0;
      field_num       = 1;
      field_has_bytes = 1'b0;
    end else begin
      // bytes past the store depth are dropped
      if (line_len < LINE_DEPTH) begin
        line_buf[line_len] = b;
        line_len++;
      end
      if (b == delim) begin
        if (mode == MODE_FIELDS && field_on(field_num)) run.push_back(SPACE_BYTE);
        if (field_num <= MAX_FIELDS) field_num++;
        field_has_bytes = 1'b0;
      end else begin
        if (mode == MODE_FIELDS && field_on(field_num)) run.push_back(b);
        field_has_bytes = 1'b1;
      end
    end
    foreach (run[i]) begin
      w.value = run[i];
      w.last  = (i == run.size() - 1);
      cut_q.push_back(w);
    end
  endfunction

  always @(posedge clk) begin : watch
    cut_word_t want;
    if (rst) begin
      mode            = MODE_FIELDS;
      delim           = 8'd9;
      fmask           = '0;
      pos_count       = '0;
      line_len        = 0;
      field_num       = 1;
      field_has_bytes = 1'b0;
      cut_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SELECT_MODE:    mode      = cfg_data[0];
          CFG_DELIMITER:      delim     = cfg_data[7:0];
          CFG_FIELD_MASK:     fmask     = cfg_data;
          CFG_POSITION_COUNT: pos_count = cfg_data[5:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready)
        predict_cut(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[13:8], s_axis_tdata[26:14]);
      if (m_axis_tvalid && m_axis_tready) begin
        words_checked++;
        if (cut_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word %02h last %b", m_axis_tdata, m_axis_tlast));
        end else begin
          want = cut_q.pop_front();
          if (m_axis_tdata !== want.value)
            report_mismatch($sformatf("out_byte %02h, expected %02h", m_axis_tdata, want.value));
          if (m_axis_tlast !== want.last)
            report_mismatch($sformatf("last_of_run %b, expected %b on byte %02h",
                                      m_axis_tlast, want.last, want.value));
        end
      end
    end
    words_due = cut_q.size();
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 100ps
// top of the text cutter testbench: clock, reset, register writes, input words
// in bursts and gaps, output stalls and the verdict
// depends on tbfc_pkg, text_byte_and_field_cutter_unit, cutter_checker
module tb;
  import tbfc_pkg::*;

  // slowest correct run stays far below this: input words with gaps, byte
  // mode newlines walking up to 63 entries, output stalls and one receiver hold
  localparam int unsigned LIMIT_CYCLES  = 400000;
  // time allowed for a word that gives no output to be done
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned LIST_SIZE     = 63;

  typedef struct packed {
    logic             act;
    logic [7:0]       text;
    logic [5:0]       slot;
    logic [POS_W-1:0] pos;
  } in_word_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int unsigned fail_count;
  int unsigned words_due;
  int unsigned words_checked;

  int unsigned cycle_count = 0;
  int unsigned words_queued = 0;
  int unsigned words_sent = 0;
  int unsigned phase_count = 0;

  // sender and receiver knobs, changed between phases
  in_word_t    word_q[$];
  bit          sender_busy = 1'b0;
  bit          sender_gaps = 1'b1;
  bit          sink_stalls = 1'b1;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;

  text_byte_and_field_cutter_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  cutter_checker chk (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .words_due     (words_due),
    .words_checked (words_checked)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d words still due", cycle_count, words_due);
      $display("FAIL text_byte_and_field_cutter_unit");
      $finish;
    end
  end

  // sender: pops queued words, offers them in bursts with random gaps between
  initial begin : sender
    in_word_t    w;
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    @(negedge clk);
    forever begin
      if (word_q.size() == 0) begin
        sender_busy = 1'b0;
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
      end else begin
        sender_busy = 1'b1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap = sender_gaps ? $urandom_range(1, 5) : 0;
          if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
          end
        end
        w = word_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.act;
        s_axis_tdata  <= {5'd0, w.pos, w.slot, w.text};
        // wait for the handshake
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        words_sent++;
        burst_left--;
        @(negedge clk);
      end
    end
  end

  // receiver: always ready, a rotating stall pattern that is redrawn at random,
  // or a long hold when asked for one
  initial begin : sink
    logic [7:0]  stall_pattern;
    int unsigned stall_phase;
    stall_pattern = 8'hFF;
    stall_phase   = 0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!sink_stalls) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= stall_pattern[stall_phase % 8];
        stall_phase = (stall_phase + 1) % 32;
        if (stall_phase == 0) stall_pattern = 8'($urandom_range(1, 255));
      end
    end
  end

  // register write, only called while the block is idle
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // wait until every word is taken and every output word has come, then let
  // the block finish any word that gives no output
  task automatic settle();
    do @(posedge clk); while (word_q.size() != 0 || sender_busy);
    while (words_due != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    phase_count++;
  endtask

  function automatic logic [POS_W-1:0] rand_position();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 80) return POS_W'($urandom_range(1, 16));
    return POS_W'($urandom_range(1, 4096));
  endfunction

  // text words carry random filler in the unused fields
  function automatic void queue_text(logic [7:0] b);
    in_word_t w;
    w.act  = ACT_TEXT;
    w.text = b;
    w.slot = 6'($urandom_range(0, 63));
    w.pos  = POS_W'($urandom_range(0, 8191));
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic void queue_load(logic [5:0] slot, logic [POS_W-1:0] pos);
    in_word_t w;
    w.act  = ACT_LOAD;
    w.text = 8'($urandom_range(0, 255));
    w.slot = slot;
    w.pos  = pos;
    word_q.push_back(w);
    words_queued++;
  endfunction

  function automatic logic [7:0] rand_text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NEWLINE_BYTE) b = 8'hEA;
    return b;
  endfunction

  // one line with separators at random, a stray list load now and then
  function automatic void queue_line(int unsigned len, logic [7:0] sep);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) queue_load(6'($urandom_range(0, 63)), rand_position());
      if ($urandom_range(0, 4) == 0) queue_text(sep);
      else queue_text(rand_text_byte());
    end
    queue_text(NEWLINE_BYTE);
  endfunction

  // random lines until about the given number of words is queued
  function automatic void queue_random_lines(int unsigned words, logic [7:0] sep);
    int unsigned stop_at;
    stop_at = words_queued + words;
    while (words_queued < stop_at) begin
      if ($urandom_range(0, 3) == 0) queue_line($urandom_range(13, 40), sep);
      else queue_line($urandom_range(0, 12), sep);
    end
  endfunction

  // a line with the given number of fields of 0..1 bytes each
  function automatic void queue_field_line(int unsigned fields, logic [7:0] sep);
    logic [7:0] b;
    for (int f = 0; f < fields; f++) begin
      for (int k = $urandom_range(0, 1); k > 0; k--) begin
        b = rand_text_byte();
        if (b == sep) b = ~sep;
        queue_text(b);
      end
      if (f + 1 < fields) queue_text(sep);
    end
    queue_text(NEWLINE_BYTE);
  endfunction

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: reset settings give field mode on tab with nothing selected,
    // so only the newline comes out
    queue_text("a");
    queue_text(8'h09);
    queue_text("b");
    queue_text(NEWLINE_BYTE);
    settle();

    // empty selected fields give a space at their delimiter, a nonempty
    // selected last field gives a space before the newline
    write_reg(CFG_DELIMITER, 64'(","));
    write_reg(CFG_FIELD_MASK, 64'hD);
    queue_text(",");
    queue_text("A");
    queue_text(",");
    queue_text(",");
    queue_text(8'hFF);
    queue_text(8'h00);
    queue_text(NEWLINE_BYTE);
    settle();

    // byte mode: position zero, a position past the line end, the top
    // position, out of order positions and a slot beyond the list
    write_reg(CFG_SELECT_MODE, 64'(MODE_BYTES));
    write_reg(CFG_POSITION_COUNT, 64'd6);
    queue_load(6'd0, 13'd3);
    queue_load(6'd1, 13'd1);
    queue_load(6'd2, 13'd0);
    queue_load(6'd3, 13'd4096);
    queue_load(6'd4, 13'd2);
    queue_load(6'd5, 13'd9);
    queue_load(6'd63, 13'd5);
    queue_text("x");
    queue_text("y");
    queue_text("z");
    queue_text("w");
    queue_text(NEWLINE_BYTE);
    queue_text(NEWLINE_BYTE);
    settle();

    // random fields on comma with a random mask, both sides idling
    write_reg(CFG_SELECT_MODE, 64'(MODE_FIELDS));
    write_reg(CFG_FIELD_MASK, {32'($urandom()), 32'($urandom())});
    queue_random_lines(16, ",");
    settle();

    // top delimiter value, every field selected, more than 64 fields in one
    // line; the receiver holds off for a long stretch while the sender keeps
    // offering words, so the block backs up and stalls its input
    sender_gaps = 1'b0;
    sink_stalls = 1'b0;
    write_reg(CFG_DELIMITER, 64'hFF);
    write_reg(CFG_FIELD_MASK, '1);
    hold_request = 1'b1;
    queue_field_line(66, 8'hFF);
    settle();

    // fill the whole position list, then walk all 63 entries per line
    sender_gaps = 1'b1;
    sink_stalls = 1'b1;
    write_reg(CFG_SELECT_MODE, 64'(MODE_BYTES));
    write_reg(CFG_POSITION_COUNT, 64'(LIST_SIZE));
    for (int s = 0; s < LIST_SIZE; s++) queue_load(6'(s), rand_position());
    queue_random_lines(16, ",");
    settle();

    // empty position list: each line gives only its newline
    sender_gaps = 1'b0;
    write_reg(CFG_SELECT_MODE, 64'(MODE_BYTES));
    write_reg(CFG_POSITION_COUNT, 64'd0);
    queue_random_lines(8, ",");
    settle();

    // newline as delimiter: it still ends the line
    sender_gaps = 1'b1;
    write_reg(CFG_SELECT_MODE, 64'(MODE_FIELDS));
    write_reg(CFG_DELIMITER, 64'(NEWLINE_BYTE));
    write_reg(CFG_FIELD_MASK, {32'($urandom()), 32'($urandom())});
    queue_random_lines(12, NEWLINE_BYTE);
    settle();

    // random list length with the top positions at the front of the list
    sender_gaps = 1'b0;
    write_reg(CFG_SELECT_MODE, 64'(MODE_BYTES));
    write_reg(CFG_POSITION_COUNT, 64'($urandom_range(3, 63)));
    queue_load(6'd0, 13'd4096);
    queue_load(6'd1, 13'd4095);
    queue_load(6'd2, 13'd1);
    queue_random_lines(12, ",");
    settle();

    $display("sent %0d input words, checked %0d output words over %0d phases",
             words_sent, words_checked, phase_count);
    $display("both modes, delimiters 9/10/44/255, masks empty to full, list lengths 0 to 63");
    if (fail_count == 0) begin
      $display("PASS text_byte_and_field_cutter_unit");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("FAIL text_byte_and_field_cutter_unit");
    end
    $finish;
  end

endmodule
